>>> src/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and codes for the target track table.
// ----------------------------------------------------------------------------
`default_nettype none
package ttt_pkg;

  typedef enum logic [1:0] {
    OP_FRAME_START = 2'd0,
    OP_DETECT      = 2'd1,
    OP_FRAME_END   = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_ERASED   = 3'd2,
    ST_REJECTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_FSTART   = 3'd5,
    ST_FEND     = 3'd6
  } status_e;

  // register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LIFE_RELOAD  = 2'd2;
  localparam logic [1:0] REG_NEAR_DIST    = 2'd3;

  // one table entry
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic [7:0]  life;
    logic [4:0]  label;
  } entry_t;

endpackage
`default_nettype wire

>>> src/target_track_table_unit.sv
// ----------------------------------------------------------------------------
// target_track_table_unit
// Track table with nearest-neighbor association, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Usage: words enter on the s_axis channel (operation, box, no_new_entries)
// and each operation 0..2 yields one result word on m_axis (status, slot,
// label, entry_count). Operation 3 is taken and dropped without a result.
// Flow: the entry memory serves a sequencer that walks the table, one entry
// per cycle in its scan. frame_start and frame_end take one scan each, and
// frame_end compacts in the same pass. A detection scans and then decides;
// an erase then moves each later entry down one slot, through S_SHIFT_RD
// and S_SHIFT_WR per entry. Worst case is a detection erasing slot 0 of a
// full table. The block takes no new word until its result word has been
// accepted; a stalled receiver holds the result and the block.
// Reset clears the count and the registers to their defaults; table entries
// are undefined until written but only entries below count are read.
// Configuration via APB, pready always high; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module target_track_table_unit #(
  parameter int MAX_ENTRIES   = 32,
  parameter int EDGE_PAD_LOW  = 1,
  parameter int EDGE_PAD_HIGH = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [1:0] operation, [13:2] box_x, [25:14] box_y, [37:26] box_w, [49:38] box_h,
  // [50] no_new_entries, [55:51] zero
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [2:0] status, [7:3] slot, [12:8] label, [18:13] entry_count, [23:19] zero
  output logic [23:0]      m_axis_tdata_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_OUT
  } state_e;

  // configuration
  logic [12:0] fw_q, fh_q;
  logic [7:0]  reload_q;
  logic [11:0] near_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= 13'd640;
      fh_q     <= 13'd480;
      reload_q <= 8'd10;
      near_q   <= 12'd100;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ttt_pkg::REG_FRAME_WIDTH:  fw_q     <= pwdata[12:0];
        ttt_pkg::REG_FRAME_HEIGHT: fh_q     <= pwdata[12:0];
        ttt_pkg::REG_LIFE_RELOAD:  reload_q <= pwdata[7:0];
        ttt_pkg::REG_NEAR_DIST:    near_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ttt_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, fw_q};
      ttt_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, fh_q};
      ttt_pkg::REG_LIFE_RELOAD:  prdata = {24'd0, reload_q};
      default:                   prdata = {20'd0, near_q};
    endcase
  end

  // entry memory: one write and one read port, registered read
  ttt_pkg::entry_t mem [MAX_ENTRIES];
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  ttt_pkg::entry_t wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // sequencer registers
  state_e           state_q;
  logic [1:0]       op_q;
  logic [11:0]      bx_q, by_q, bw_q, bh_q;
  logic             forbid_q;
  logic [CW-1:0]    cnt_q;       // entries in use
  logic [CW-1:0]    rd_q;        // next read index
  logic [CW-1:0]    wr_q;        // index of entry in rdata_q / write index
  logic [CW-1:0]    n_q;         // compaction output index
  logic             rvalid_q;    // rdata_q holds entry wr_q
  logic             found_q;
  logic [AW-1:0]    best_q;
  logic [12:0]      bestd_q;
  logic [4:0]       bestlab_q;
  logic             inside_q;
  logic [2:0]       st_q;
  logic [4:0]       slot_q, lab_q;
  logic             ovalid_q;
  logic [23:0]      odata_q;

  // shared distance unit
  logic [11:0] dx, dy;
  logic [12:0] dsum;
  logic        near_hit;
  assign dx = (bx_q > rdata_q.x) ? bx_q - rdata_q.x : rdata_q.x - bx_q;
  assign dy = (by_q > rdata_q.y) ? by_q - rdata_q.y : rdata_q.y - by_q;
  assign dsum = {1'b0, dx} + {1'b0, dy};
  assign near_hit = (dx <= near_q) && (dy <= near_q);

  // edge test on the incoming word
  logic [11:0] ix, iy, iw, ih;
  logic [13:0] xr, yr, fxl, fyl;
  logic        inside_d;
  assign ix = s_axis_tdata_i[13:2];
  assign iy = s_axis_tdata_i[25:14];
  assign iw = s_axis_tdata_i[37:26];
  assign ih = s_axis_tdata_i[49:38];
  assign xr = {2'b0, ix} + {2'b0, iw};
  assign yr = {2'b0, iy} + {2'b0, ih};
  assign fxl = {1'b0, fw_q} + 14'(EDGE_PAD_HIGH);
  assign fyl = {1'b0, fh_q} + 14'(EDGE_PAD_HIGH);
  assign inside_d = ({20'd0, ix} > 32'(EDGE_PAD_LOW)) && ({20'd0, iy} > 32'(EDGE_PAD_LOW))
                    && (xr < fxl) && (yr < fyl);

  assign s_axis_tready_o = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  logic last_rd;
  assign last_rd = rvalid_q && (wr_q + 1'b1 >= cnt_q);

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = wr_q[AW-1:0];
    wdata = rdata_q;
    raddr = rd_q[AW-1:0];
    unique case (state_q)
      S_SCAN: begin
        if (rvalid_q) begin
          unique case (op_q)
            ttt_pkg::OP_FRAME_START: begin
              we = 1'b1;
              if (rdata_q.life != 8'd0) wdata.life = rdata_q.life - 8'd1;
            end
            ttt_pkg::OP_FRAME_END: begin
              we    = (rdata_q.life != 8'd0);
              waddr = n_q[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      S_DECIDE: begin
        if (!found_q) begin
          we    = inside_q && !forbid_q && (cnt_q < CW'(MAX_ENTRIES));
          waddr = cnt_q[AW-1:0];
          wdata = '{x: bx_q, y: by_q, w: bw_q, h: bh_q, life: reload_q,
                    label: 5'(cnt_q)};
        end else if (inside_q) begin
          we    = 1'b1;
          waddr = best_q;
          wdata = '{x: bx_q, y: by_q, w: bw_q, h: bh_q, life: reload_q,
                    label: bestlab_q};
        end
        raddr = rd_q[AW-1:0];
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = AW'(wr_q - 1'b1);
        wdata = rdata_q;
        wdata.label = (rdata_q.label != 5'd0) ? rdata_q.label - 5'd1 : 5'd0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      rvalid_q <= 1'b0;
      rd_q <= '0; wr_q <= '0; n_q <= '0;
      found_q <= 1'b0;
      op_q <= '0; forbid_q <= 1'b0; inside_q <= 1'b0;
      bx_q <= '0; by_q <= '0; bw_q <= '0; bh_q <= '0;
      best_q <= '0; bestd_q <= '0; bestlab_q <= '0;
      st_q <= '0; slot_q <= '0; lab_q <= '0;
      odata_q <= '0;
    end else begin
      // result register: loaded in S_OUT, cleared when taken
      if (state_q == S_OUT && (!ovalid_q || m_axis_tready_i)) ovalid_q <= 1'b1;
      else if (ovalid_q && m_axis_tready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o &&
              s_axis_tdata_i[1:0] != ttt_pkg::OP_NONE) begin
            op_q     <= s_axis_tdata_i[1:0];
            bx_q     <= ix; by_q <= iy; bw_q <= iw; bh_q <= ih;
            forbid_q <= s_axis_tdata_i[50];
            inside_q <= inside_d;
            rd_q     <= '0;
            wr_q     <= '0;
            n_q      <= '0;
            rvalid_q <= 1'b0;
            found_q  <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue reads 0..cnt-1, handle entry wr_q when valid
          if (rd_q < cnt_q) begin
            rd_q <= rd_q + 1'b1;
          end
          rvalid_q <= (rd_q < cnt_q);
          if (rvalid_q) begin
            wr_q <= wr_q + 1'b1;
            if (op_q == ttt_pkg::OP_DETECT && near_hit && (!found_q || dsum < bestd_q)) begin
              found_q   <= 1'b1;
              best_q    <= wr_q[AW-1:0];
              bestd_q   <= dsum;
              bestlab_q <= rdata_q.label;
            end
            if (op_q == ttt_pkg::OP_FRAME_END && rdata_q.life != 8'd0) n_q <= n_q + 1'b1;
          end
          if (cnt_q == '0 || last_rd) begin
            state_q  <= (op_q == ttt_pkg::OP_DETECT) ? S_DECIDE : S_OUT;
            slot_q <= '0; lab_q <= '0;
            if (op_q == ttt_pkg::OP_FRAME_START) st_q <= ttt_pkg::ST_FSTART;
            else st_q <= ttt_pkg::ST_FEND;
            if (op_q == ttt_pkg::OP_FRAME_END)
              cnt_q <= (rvalid_q && rdata_q.life != 8'd0) ? n_q + 1'b1 : n_q;
          end
        end
        S_DECIDE: begin
          if (!found_q) begin
            state_q <= S_OUT;
            if (forbid_q || !inside_q) begin
              st_q <= ttt_pkg::ST_REJECTED;
              slot_q <= '0; lab_q <= '0;
            end else if (cnt_q >= CW'(MAX_ENTRIES)) begin
              st_q <= ttt_pkg::ST_FULL;
              slot_q <= '0; lab_q <= '0;
            end else begin
              st_q   <= ttt_pkg::ST_ADDED;
              slot_q <= 5'(cnt_q);
              lab_q  <= 5'(cnt_q);
              cnt_q  <= cnt_q + 1'b1;
            end
          end else if (inside_q) begin
            st_q <= ttt_pkg::ST_UPDATED;
            slot_q <= 5'(best_q); lab_q <= bestlab_q;
            state_q <= S_OUT;
          end else begin
            st_q <= ttt_pkg::ST_ERASED;
            slot_q <= 5'(best_q); lab_q <= bestlab_q;
            rd_q <= CW'(best_q) + 1'b1;
            wr_q <= CW'(best_q) + 1'b1;
            state_q <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          if (rd_q >= cnt_q) begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_OUT;
          end else begin
            wr_q    <= rd_q;
            rd_q    <= rd_q + 1'b1;
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          state_q <= S_SHIFT_RD;
        end
        S_OUT: begin
          if (!ovalid_q || m_axis_tready_i) begin
            odata_q  <= {5'd0, 6'(cnt_q), lab_q, slot_q, st_q};
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/ttt_checker.sv
// ----------------------------------------------------------------------------
// ttt_checker
// Port-level checks for the target track table unit.
// ----------------------------------------------------------------------------
`default_nettype none
module ttt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed under stall");

  // no new word taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("ready while result pending");

  // count never exceeds table depth
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[18:13] <= 6'd32)
    else $error("entry count too large");

  // status code in range
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] != 3'd7)
    else $error("bad status");

endmodule

bind target_track_table_unit ttt_checker u_ttt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o)
);
`default_nettype wire
